// File: rtl/gmat_pkg.sv
package gmat_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] ANY_BYTE  = 8'd63;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } action_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic       fire;
        action_t    op;
        logic [7:0] ch;
    } gmat_ctrl_t;

endpackage

// File: rtl/wildcard_glob_matcher_top.sv
// Glob matcher: a row of MAX_PATTERN cells, one per pattern byte.
// Throughput: one request per cycle; the star closure ripples through the row.
// An end request's verdict shows on m_* in the cycle after its acceptance.
// Output register stalls input only while a verdict waits and m_tready is low.
// Reset: empty pattern, only the empty prefix matching, overflow clear.
module wildcard_glob_matcher_top
    import gmat_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic [1:0] s_tuser,   // [1:0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] matched, [7:1] zero
    output logic [0:0] m_tuser    // [0] overflow
);

    gmat_ctrl_t ctrl;

    logic [MAX_PATTERN:0]   act_old;
    logic [MAX_PATTERN:0]   act_new;
    logic [MAX_PATTERN+1:0] used;
    logic [MAX_PATTERN-1:0] hit;

    logic act0_reg;
    logic act0_next;
    logic ovf_reg;
    logic ovf_next;
    logic full;
    logic matched;

    logic out_valid_reg;
    logic out_match_reg;
    logic out_ovf_reg;

    assign s_tready  = ~out_valid_reg | m_tready;
    assign ctrl.fire = s_tvalid & s_tready;
    assign ctrl.op   = action_t'(s_tuser);
    assign ctrl.ch   = s_tdata;

    assign act_old[0] = act0_reg;
    assign act_new[0] = act0_next;
    assign used[0]    = 1'b1;
    assign used[MAX_PATTERN+1] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            gmat_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .act_old_in (act_old[k]),
                .act_new_in (act_new[k]),
                .prev_used  (used[k]),
                .next_used  (used[k+2]),
                .act_old    (act_old[k+1]),
                .act_new    (act_new[k+1]),
                .used       (used[k+1]),
                .hit        (hit[k])
            );
        end
    endgenerate

    assign full    = used[MAX_PATTERN];
    assign matched = ~ovf_reg & ((act0_reg & ~used[1]) | (|hit));

    always_comb
    begin
        act0_next = act0_reg;
        ovf_next  = ovf_reg;
        unique case (ctrl.op)
            ACT_CLEAR:
            begin
                act0_next = 1'b1;
                ovf_next  = 1'b0;
            end
            ACT_APPEND:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
            end
            ACT_TEXT:
            begin
                act0_next = 1'b0;
            end
            default:
            begin
                act0_next = act0_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act0_reg      <= 1'b1;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.fire)
            begin
                act0_reg <= act0_next;
                ovf_reg  <= ovf_next;
            end
            if (ctrl.fire && (ctrl.op == ACT_END))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire && (ctrl.op == ACT_END))
        begin
            out_match_reg <= matched;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_match_reg};
    assign m_tuser  = out_ovf_reg;

endmodule

// File: rtl/gmat_cell.sv
// One pattern position k: holds pattern byte k, whether it is in use, and
// the match bit of prefix k+1.
module gmat_cell
    import gmat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  gmat_ctrl_t ctrl,
    input  logic       act_old_in,  // prefix k, current value
    input  logic       act_new_in,  // prefix k, value after this request
    input  logic       prev_used,   // position k-1 in use (1 for the first cell)
    input  logic       next_used,   // position k+1 in use (0 for the last cell)
    output logic       act_old,
    output logic       act_new,
    output logic       used,
    output logic       hit
);

    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic       used_reg;
    logic       used_next;
    logic       act_reg;
    logic       slot;
    logic       is_star;
    logic       raw;

    assign slot    = prev_used & ~used_reg;
    assign is_star = (pat_reg == STAR_BYTE);

    always_comb
    begin
        act_new   = act_reg;
        used_next = used_reg;
        pat_next  = pat_reg;
        raw       = 1'b0;
        unique case (ctrl.op)
            ACT_CLEAR:
            begin
                act_new   = 1'b0;
                used_next = 1'b0;
            end
            ACT_APPEND:
            begin
                if (slot)
                begin
                    act_new   = act_new_in & (ctrl.ch == STAR_BYTE);
                    pat_next  = ctrl.ch;
                    used_next = 1'b1;
                end
                else
                begin
                    act_new = act_reg | (used_reg & is_star & act_new_in);
                end
            end
            ACT_TEXT:
            begin
                // a star keeps its own bit; other bytes step from prefix k
                raw = used_reg & (is_star ? act_reg :
                      (act_old_in & ((pat_reg == ANY_BYTE) || (pat_reg == ctrl.ch))));
                act_new = raw | (used_reg & is_star & act_new_in);
            end
            default:
            begin
                act_new = act_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            act_reg  <= 1'b0;
        end
        else if (ctrl.fire)
        begin
            used_reg <= used_next;
            act_reg  <= act_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
        begin
            pat_reg <= pat_next;
        end
    end

    assign act_old = act_reg;
    assign used    = used_reg;
    // this cell is the last pattern byte and its prefix matches
    assign hit     = act_reg & used_reg & ~next_used;

endmodule

// File: tb/sv/glob_board_pkg.sv
`timescale 1ns / 100ps

package glob_board_pkg;

    import gmat_pkg::*;

    typedef struct packed {
        logic matched;
        logic overflow;
    } glob_verdict_t;

    class glob_board;
        logic [7:0]               pat_bytes [MAX_PATTERN_DEF];
        int unsigned              pat_len;
        logic [MAX_PATTERN_DEF:0] live_prefixes;
        logic                     pat_overflow;
        glob_verdict_t            verdicts_due [$];
        int                       errors;

        function new();
            pat_len       = 0;
            live_prefixes = 1;
            pat_overflow  = 1'b0;
            errors        = 0;
        endfunction

        // a prefix ending in a star matches wherever the prefix before the star does
        function void close_stars();
            for (int k = 0; k < pat_len; k++)
                if (pat_bytes[k] == STAR_BYTE && live_prefixes[k])
                    live_prefixes[k+1] = 1'b1;
        endfunction

        function void note_request(action_t act, logic [7:0] ch);
            logic [MAX_PATTERN_DEF:0] nxt;
            glob_verdict_t            v;
            case (act)
                ACT_CLEAR:
                begin
                    pat_len       = 0;
                    live_prefixes = 1;
                    pat_overflow  = 1'b0;
                end
                ACT_APPEND:
                begin
                    if (pat_len >= MAX_PATTERN_DEF)
                        pat_overflow = 1'b1;
                    else
                    begin
                        pat_bytes[pat_len] = ch;
                        pat_len++;
                        close_stars();
                    end
                end
                ACT_TEXT:
                begin
                    nxt = '0;
                    for (int k = 0; k < pat_len; k++)
                    begin
                        if (pat_bytes[k] == STAR_BYTE)
                        begin
                            if (live_prefixes[k+1])
                                nxt[k+1] = 1'b1;
                        end
                        else if (live_prefixes[k] &&
                                 (pat_bytes[k] == ANY_BYTE || pat_bytes[k] == ch))
                            nxt[k+1] = 1'b1;
                    end
                    live_prefixes = nxt;
                    close_stars();
                end
                default:
                begin
                    v.matched  = !pat_overflow && live_prefixes[pat_len];
                    v.overflow = pat_overflow;
                    verdicts_due.push_back(v);
                end
            endcase
        endfunction

        function void check_verdict(logic matched, logic overflow);
            glob_verdict_t exp_v;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, actual matched %0b overflow %0b",
                         $time, matched, overflow);
                errors++;
                return;
            end
            exp_v = verdicts_due.pop_front();
            if (matched !== exp_v.matched)
            begin
                $display("%0t: matched mismatch, expected %0b, actual %0b",
                         $time, exp_v.matched, matched);
                errors++;
            end
            if (overflow !== exp_v.overflow)
            begin
                $display("%0t: overflow mismatch, expected %0b, actual %0b",
                         $time, exp_v.overflow, overflow);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import gmat_pkg::*;
    import glob_board_pkg::*;

    localparam int IDLE_PCT  = 27;
    localparam int HOLD_CYC  = 300;
    localparam int ITEM_GOAL = 750;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic [1:0] s_tuser  = ACT_CLEAR;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;

    glob_board board = new();
    int        req_count = 0;
    bit        calm      = 1'b0;
    bit        hold_req  = 1'b0;

    wildcard_glob_matcher_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] character
        .s_tuser  (s_tuser),   // [1:0] action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [0] matched, [7:1] zero
        .m_tuser  (m_tuser)    // [0] overflow
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one request: random gaps, then hold valid until accepted
    task automatic send_req(action_t act, logic [7:0] ch);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(act, ch);
        req_count++;
    endtask

    function automatic logic [7:0] pick_pat_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return STAR_BYTE;
        else if (r < 5)
            return ANY_BYTE;
        else if (r < 9)
            return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    // clear, pattern, a text built to fit it (sometimes spoiled), end, then extras
    task automatic run_job(int forced_len);
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        int         plen;
        int         pos;

        send_req(ACT_CLEAR, 8'($urandom_range(0, 255)));
        if (forced_len >= 0)
            plen = forced_len;
        else if ($urandom_range(0, 9) == 0)
            plen = $urandom_range(28, 35);
        else
            plen = $urandom_range(0, 6);
        for (int k = 0; k < plen; k++)
        begin
            pat.push_back(pick_pat_byte());
            send_req(ACT_APPEND, pat[k]);
        end

        foreach (pat[k])
        begin
            if (pat[k] == STAR_BYTE)
                repeat ($urandom_range(0, 3)) txt.push_back(pick_text_byte());
            else if (pat[k] == ANY_BYTE)
                txt.push_back(pick_text_byte());
            else
                txt.push_back(pat[k]);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            pos = $urandom_range(0, txt.size());
            case ($urandom_range(0, 2))
                0: txt.insert(pos, pick_text_byte());
                1: if (pos < txt.size()) txt.delete(pos);
                default: if (pos < txt.size()) txt[pos] = pick_text_byte();
            endcase
        end
        foreach (txt[k])
            send_req(ACT_TEXT, txt[k]);
        send_req(ACT_END, 8'($urandom_range(0, 255)));

        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(0, 3)) send_req(ACT_TEXT, pick_text_byte());
            send_req(ACT_END, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0)
        begin
            send_req(ACT_APPEND, pick_pat_byte());
            send_req(ACT_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // receiver: random stalls, one long hold-off, and a calm stretch
    initial
    begin
        int  stall_left;
        bit  held;
        stall_left = 0;
        held       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYC;
                m_tready  <= 1'b0;
            end
            else if (stall_left > 0)
                stall_left--;
            else
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_verdict(m_tdata[0], m_tuser[0]);

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty pattern against empty and non-empty text
        send_req(ACT_END,    8'hFF);
        send_req(ACT_TEXT,   8'h00);
        send_req(ACT_END,    8'h00);
        // lone star, then a repeated end continuing the same text
        send_req(ACT_CLEAR,  8'hA5);
        send_req(ACT_APPEND, STAR_BYTE);
        send_req(ACT_END,    8'h5A);
        send_req(ACT_TEXT,   8'hFF);
        send_req(ACT_END,    8'h00);
        // question mark matches a literal star in the text
        send_req(ACT_CLEAR,  8'h00);
        send_req(ACT_APPEND, 8'h61);
        send_req(ACT_APPEND, ANY_BYTE);
        send_req(ACT_TEXT,   8'h61);
        send_req(ACT_TEXT,   STAR_BYTE);
        send_req(ACT_END,    8'hFF);
        send_req(ACT_TEXT,   8'h78);
        send_req(ACT_END,    8'h00);
        // literal appended after text starts out not matching
        send_req(ACT_CLEAR,  8'hFF);
        send_req(ACT_APPEND, STAR_BYTE);
        send_req(ACT_TEXT,   8'h71);
        send_req(ACT_APPEND, 8'h71);
        send_req(ACT_END,    8'h00);
        send_req(ACT_APPEND, STAR_BYTE);
        send_req(ACT_TEXT,   8'h71);
        send_req(ACT_END,    8'h00);
        // extreme literal bytes
        send_req(ACT_CLEAR,  8'h00);
        send_req(ACT_APPEND, 8'h00);
        send_req(ACT_APPEND, 8'hFF);
        send_req(ACT_TEXT,   8'h00);
        send_req(ACT_TEXT,   8'hFF);
        send_req(ACT_END,    8'hFF);

        // first random job always overruns the pattern store
        run_job(MAX_PATTERN_DEF + 1);
        while (req_count < ITEM_GOAL)
        begin
            if (req_count > 200 && !hold_req)
                hold_req = 1'b1;
            calm = (req_count >= 400 && req_count < 520);
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(3, 8))
                    send_req(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else
                run_job(-1);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (board.pending() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
